/* hdl/smv_pkg.sv */
// shared types and constants for the sparse matrix-vector multiply core
// no dependencies

package smv_pkg;

  localparam int SMV_MAX_COLUMNS   = 1024;
  localparam int SMV_COL_W         = 10;
  localparam int SMV_VAL_W         = 32;
  localparam int SMV_PROD_W        = 64;
  localparam int SMV_ROW_W         = 20;
  localparam int SMV_COLCNT_W      = 11;
  localparam int SMV_ROWCNT_W      = 21;
  localparam int SMV_CFG_DATA_W    = 21;
  localparam int SMV_FRAC_W        = 16;

  localparam logic [SMV_COLCNT_W-1:0] SMV_COLCNT_RST = 11'd1024;
  localparam logic [SMV_ROWCNT_W-1:0] SMV_ROWCNT_RST = 21'd1024;
  localparam logic [SMV_ROWCNT_W-1:0] SMV_ROW_LIMIT  = 21'd1048576;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACC   = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic {
    CFG_COLUMN_COUNT = 1'b0,
    CFG_ROW_COUNT    = 1'b1
  } cfg_idx_t;

endpackage

/* hdl/smv_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module smv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/sparse_matrix_vector_multiply_core.sv */
// csr sparse matrix times vector core, signed q16.16 in and out
// depends on smv_pkg and smv_ram
//
// usage:
//   load the vector with load words (opcode 0), then stream the nonzeros of
//   each row as accumulate words (opcode 1) and close every row with a close
//   word (opcode 2). each close word gives one result word: the row sum,
//   the row number, a last-row flag, a clip flag and a bad-column flag.
//   load and accumulate words give no result; opcode 3 is dropped.
//   column_count and row_count are written over the cfg channel while idle;
//   cfg_ready is always high.
// timing:
//   one word is accepted per cycle while in_stall is low. a word passes a
//   vector store read, a registered 32x32 multiply and the 64-bit saturating
//   accumulator; a close word's result is registered in the output register.
//   a load is visible to an accumulate word accepted in the next cycle.
// stall:
//   while a result waits under out_stall, load and accumulate words keep
//   flowing; in_stall rises only when a close word reaches the accumulator
//   and the output register is still held.
// reset:
//   clears the pipeline, accumulator, flags and row counter and restores the
//   register defaults; vector store contents are undefined until loaded.

module sparse_matrix_vector_multiply_core
  import smv_pkg::*;
#(
  parameter int MAX_COLUMNS = SMV_MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SMV_COL_W-1:0]       in_column_index,
  input  logic [1:0]                 in_opcode,
  input  logic signed [SMV_VAL_W-1:0] in_vector_value,
  input  logic signed [SMV_VAL_W-1:0] in_matrix_value,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SMV_VAL_W-1:0] out_row_sum,
  output logic [SMV_ROW_W-1:0]       out_row_number,
  output logic                       out_last_row,
  output logic                       out_saturated,
  output logic                       out_bad_column,

  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [SMV_CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_COLUMNS);

  // config
  logic [SMV_COLCNT_W-1:0] column_count_r;
  logic [SMV_ROWCNT_W-1:0] row_count_r;

  // stage 1: ram read in flight
  logic                        s1_v_r;
  logic                        s1_close_r;
  logic                        s1_bad_r;
  logic signed [SMV_VAL_W-1:0] s1_mval_r;

  // stage 2: product ready
  logic                         s2_v_r;
  logic                         s2_close_r;
  logic                         s2_bad_r;
  logic signed [SMV_PROD_W-1:0] s2_prod_r;

  // row state
  logic signed [SMV_PROD_W-1:0] acc_r;
  logic [SMV_ROW_W-1:0]         row_r;
  logic                         clip_r;
  logic                         fault_r;

  // output register
  logic                         out_valid_r;
  logic signed [SMV_VAL_W-1:0]  out_sum_r;
  logic [SMV_ROW_W-1:0]         out_row_r;
  logic                         out_last_r;
  logic                         out_sat_r;
  logic                         out_bad_r;

  logic                         in_fire;
  logic                         col_in_store;
  logic                         col_ok;
  logic                         load_we;
  logic                         s1_take;
  logic [AW-1:0]                ram_addr;
  logic signed [SMV_VAL_W-1:0]  ram_rdata;

  logic                         out_free;
  logic                         s2_go;
  logic                         s1_go;
  logic                         acc_fire;
  logic                         close_fire;

  logic signed [SMV_PROD_W-1:0] sum;
  logic                         ovf;
  logic signed [SMV_PROD_W-1:0] acc_nxt;
  logic                         clip_nxt;
  logic [SMV_PROD_W-SMV_FRAC_W-1:0] shifted;
  logic signed [SMV_VAL_W-1:0]  sum_sat;
  logic                         out_clip;
  logic [SMV_ROWCNT_W-1:0]      rows_eff;
  logic [SMV_ROWCNT_W-1:0]      row_inc;
  logic                         last;

  assign cfg_ready = 1'b1;

  // handshake and pipeline advance
  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = !s2_v_r || !s2_close_r || out_free;
  assign s1_go    = !s1_v_r || s2_go;
  assign in_stall = !s1_go;
  assign in_fire  = in_valid && s1_go;

  assign acc_fire   = s2_v_r && !s2_close_r;
  assign close_fire = s2_v_r && s2_close_r && out_free;

  // decode
  assign ram_addr     = AW'(in_column_index);
  assign col_in_store = 32'(in_column_index) < 32'(MAX_COLUMNS);
  assign col_ok       = col_in_store && ({1'b0, in_column_index} < column_count_r);

  always_comb begin
    load_we = 1'b0;
    s1_take = 1'b0;
    case (in_opcode)
      OP_LOAD:  load_we = in_fire && col_in_store;
      OP_ACC:   s1_take = in_fire;
      OP_CLOSE: s1_take = in_fire;
      default:  ;
    endcase
  end

  smv_ram #(
    .WIDTH (SMV_VAL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (ram_addr),
    .wdata (in_vector_value),
    .re    (s1_take && col_ok),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // saturating accumulate
  always_comb begin
    sum      = acc_r + s2_prod_r;
    ovf      = (acc_r[SMV_PROD_W-1] == s2_prod_r[SMV_PROD_W-1]) &&
               (sum[SMV_PROD_W-1] != acc_r[SMV_PROD_W-1]);
    acc_nxt  = sum;
    clip_nxt = clip_r;
    if (ovf) begin
      clip_nxt = 1'b1;
      acc_nxt  = acc_r[SMV_PROD_W-1] ? {1'b1, {(SMV_PROD_W-1){1'b0}}}
                                     : {1'b0, {(SMV_PROD_W-1){1'b1}}};
    end
  end

  // row close: floor to q16.16 and saturate
  always_comb begin
    shifted  = acc_r[SMV_PROD_W-1:SMV_FRAC_W];
    sum_sat  = shifted[SMV_VAL_W-1:0];
    out_clip = 1'b0;
    if (shifted[SMV_PROD_W-SMV_FRAC_W-1:SMV_VAL_W-1] != '0 &&
        shifted[SMV_PROD_W-SMV_FRAC_W-1:SMV_VAL_W-1] != '1) begin
      out_clip = 1'b1;
      sum_sat  = shifted[SMV_PROD_W-SMV_FRAC_W-1] ? {1'b1, {(SMV_VAL_W-1){1'b0}}}
                                                   : {1'b0, {(SMV_VAL_W-1){1'b1}}};
    end
    rows_eff = (row_count_r == '0 || row_count_r > SMV_ROW_LIMIT) ? SMV_ROW_LIMIT
                                                                   : row_count_r;
    row_inc  = {1'b0, row_r} + 1'b1;
    last     = row_inc >= rows_eff;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= SMV_COLCNT_RST;
      row_count_r    <= SMV_ROWCNT_RST;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      acc_r          <= '0;
      row_r          <= '0;
      clip_r         <= 1'b0;
      fault_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLUMN_COUNT: column_count_r <= cfg_data[SMV_COLCNT_W-1:0];
          CFG_ROW_COUNT:    row_count_r    <= cfg_data[SMV_ROWCNT_W-1:0];
          default:          ;
        endcase
      end
      if (s1_go) begin
        s1_v_r <= s1_take;
      end
      if (s2_go) begin
        s2_v_r <= s1_v_r;
      end
      if (acc_fire) begin
        if (s2_bad_r) begin
          fault_r <= 1'b1;
        end else begin
          acc_r  <= acc_nxt;
          clip_r <= clip_nxt;
        end
      end
      if (close_fire) begin
        acc_r   <= '0;
        clip_r  <= 1'b0;
        fault_r <= 1'b0;
        row_r   <= last ? '0 : row_inc[SMV_ROW_W-1:0];
      end
      if (close_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_go && s1_take) begin
      s1_close_r <= (in_opcode == OP_CLOSE);
      s1_bad_r   <= !col_ok;
      s1_mval_r  <= in_matrix_value;
    end
    if (s2_go && s1_v_r) begin
      s2_close_r <= s1_close_r;
      s2_bad_r   <= s1_bad_r;
      s2_prod_r  <= s1_mval_r * ram_rdata;
    end
    if (close_fire) begin
      out_sum_r  <= sum_sat;
      out_row_r  <= row_r;
      out_last_r <= last;
      out_sat_r  <= clip_r || out_clip;
      out_bad_r  <= fault_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_sum    = out_sum_r;
  assign out_row_number = out_row_r;
  assign out_last_row   = out_last_r;
  assign out_saturated  = out_sat_r;
  assign out_bad_column = out_bad_r;

  // checks
  a_close_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    close_fire |=> (acc_r == '0) && !clip_r && !fault_r)
    else $error("accumulator not cleared after row close");

  a_close_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    close_fire |=> out_valid_r && (out_row_r == $past(row_r)))
    else $error("row close did not produce a result word");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    close_fire && last |=> row_r == '0)
    else $error("row counter did not wrap after last row");

  a_bad_column_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc_fire && s2_bad_r |=> fault_r && $stable(acc_r))
    else $error("skipped nonzero changed accumulator or lost fault flag");

  a_no_close_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !close_fire)
    else $error("held result overwritten");

endmodule

/* dv/smv_checker.sv */
`timescale 1ns / 100ps
// checker for the sparse matrix-vector multiply core: keeps its own vector store and row state,
// predicts each row result from the accepted words and compares the result channel
// depends on smv_pkg

module smv_checker
  import smv_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [SMV_COL_W-1:0]        in_column_index,
  input  logic [1:0]                  in_opcode,
  input  logic signed [SMV_VAL_W-1:0] in_vector_value,
  input  logic signed [SMV_VAL_W-1:0] in_matrix_value,

  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [SMV_VAL_W-1:0] out_row_sum,
  input  logic [SMV_ROW_W-1:0]        out_row_number,
  input  logic                        out_last_row,
  input  logic                        out_saturated,
  input  logic                        out_bad_column,

  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [SMV_CFG_DATA_W-1:0]   cfg_data,

  output int                          error_count,
  output int                          rows_pending,
  output int                          rows_checked,
  output int                          clipped_rows,
  output int                          faulted_rows
);

  localparam longint ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam int     PRINT_CAP = 100;

  typedef struct {
    logic signed [SMV_VAL_W-1:0] sum;
    logic [SMV_ROW_W-1:0]        row;
    logic                        last;
    logic                        clip;
    logic                        fault;
  } row_result_t;

  logic signed [SMV_VAL_W-1:0] x_store [SMV_MAX_COLUMNS];
  longint                      acc;
  logic [SMV_ROW_W-1:0]        row_idx;
  logic                        clip_seen;
  logic                        fault_seen;
  logic [SMV_COLCNT_W-1:0]     col_limit;
  logic [SMV_ROWCNT_W-1:0]     row_limit;
  row_result_t                 sums_due [$];
  int                          errs;
  int                          rows;
  int                          clips;
  int                          faults;

  task automatic flag(input string msg);
    if (errs < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    errs++;
  endtask

  function automatic longint sat_accumulate(input longint a, input longint b, inout logic hit);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      hit = 1'b1;
      s = b[63] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  function automatic row_result_t predict_close();
    row_result_t r;
    longint      q;
    int          rows_in_use;
    q = acc >>> SMV_FRAC_W;
    r.clip = clip_seen;
    if (q > SUM_MAX) begin
      q = SUM_MAX;
      r.clip = 1'b1;
    end else if (q < SUM_MIN) begin
      q = SUM_MIN;
      r.clip = 1'b1;
    end
    rows_in_use = (row_limit == 0 || row_limit > SMV_ROW_LIMIT) ? int'(SMV_ROW_LIMIT)
                                                                 : int'(row_limit);
    r.sum = q[SMV_VAL_W-1:0];
    r.row = row_idx;
    r.last = (int'(row_idx) + 1) >= rows_in_use;
    r.fault = fault_seen;
    acc = 0;
    clip_seen = 1'b0;
    fault_seen = 1'b0;
    row_idx = r.last ? '0 : row_idx + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    row_result_t want;
    longint      prod;
    if (!rst_n) begin
      acc = 0;
      row_idx = '0;
      clip_seen = 1'b0;
      fault_seen = 1'b0;
      col_limit = SMV_COLCNT_RST;
      row_limit = SMV_ROWCNT_RST;
      sums_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLUMN_COUNT: col_limit = cfg_data[SMV_COLCNT_W-1:0];
          CFG_ROW_COUNT:    row_limit = cfg_data[SMV_ROWCNT_W-1:0];
          default:          ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LOAD: x_store[in_column_index] = in_vector_value;
          OP_ACC: begin
            if (in_column_index >= col_limit) begin
              fault_seen = 1'b1;
            end else begin
              prod = longint'(in_matrix_value) * longint'(x_store[in_column_index]);
              acc = sat_accumulate(acc, prod, clip_seen);
            end
          end
          OP_CLOSE: sums_due.insert(sums_due.size(), predict_close());
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        rows++;
        if (sums_due.size() == 0) begin
          flag($sformatf("row %0d result word with nothing expected", out_row_number));
        end else begin
          want = sums_due.pop_front();
          if (want.clip) clips++;
          if (want.fault) faults++;
          if (out_row_sum !== want.sum)
            flag($sformatf("row %0d: row_sum %h, expected %h", want.row, out_row_sum, want.sum));
          if (out_row_number !== want.row)
            flag($sformatf("row_number %0d, expected %0d", out_row_number, want.row));
          if (out_last_row !== want.last)
            flag($sformatf("row %0d: last_row %b, expected %b", want.row, out_last_row,
                           want.last));
          if (out_saturated !== want.clip)
            flag($sformatf("row %0d: saturated %b, expected %b", want.row, out_saturated,
                           want.clip));
          if (out_bad_column !== want.fault)
            flag($sformatf("row %0d: bad_column %b, expected %b", want.row, out_bad_column,
                           want.fault));
        end
      end
    end
    error_count  <= errs;
    rows_pending <= sums_due.size();
    rows_checked <= rows;
    clipped_rows <= clips;
    faulted_rows <= faults;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// top of the sparse matrix-vector multiply testbench: clock, reset, word stimulus, config writes,
// result-side stalls, watchdog and verdict; depends on smv_pkg, the core and smv_checker

module testbench;
  import smv_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         END_CYCLES     = 8;
  localparam int         PHASES         = 8;
  localparam int         PHASE_WORDS    = 228;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [SMV_COL_W-1:0]        in_column_index = '0;
  logic [1:0]                  in_opcode = '0;
  logic signed [SMV_VAL_W-1:0] in_vector_value = '0;
  logic signed [SMV_VAL_W-1:0] in_matrix_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SMV_VAL_W-1:0] out_row_sum;
  logic [SMV_ROW_W-1:0]        out_row_number;
  logic                        out_last_row;
  logic                        out_saturated;
  logic                        out_bad_column;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index = 1'b0;
  logic [SMV_CFG_DATA_W-1:0]   cfg_data = '0;

  int   error_count;
  int   rows_pending;
  int   rows_checked;
  int   clipped_rows;
  int   faulted_rows;

  int   words_sent = 0;
  int   burst_left = 0;
  int   col_in_use = int'(SMV_COLCNT_RST);
  bit   loaded [SMV_MAX_COLUMNS];
  logic hold_req = 1'b0;

  sparse_matrix_vector_multiply_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column_index (in_column_index),
    .in_opcode       (in_opcode),
    .in_vector_value (in_vector_value),
    .in_matrix_value (in_matrix_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_sum     (out_row_sum),
    .out_row_number  (out_row_number),
    .out_last_row    (out_last_row),
    .out_saturated   (out_saturated),
    .out_bad_column  (out_bad_column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  smv_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_column_index (in_column_index),
    .in_opcode       (in_opcode),
    .in_vector_value (in_vector_value),
    .in_matrix_value (in_matrix_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_sum     (out_row_sum),
    .out_row_number  (out_row_number),
    .out_last_row    (out_last_row),
    .out_saturated   (out_saturated),
    .out_bad_column  (out_bad_column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .rows_pending    (rows_pending),
    .rows_checked    (rows_checked),
    .clipped_rows    (clipped_rows),
    .faulted_rows    (faulted_rows)
  );

  initial forever #1 clk = ~clk;

  // mostly modest q16.16 values so sums stay in range, with some full-range and edge values
  function automatic logic [SMV_VAL_W-1:0] rand_value();
    logic [SMV_VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      7, 8: v = $urandom;
      9: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = '0;
        endcase
      end
      default: v = $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_column();
    int live;
    live = (col_in_use > SMV_MAX_COLUMNS) ? SMV_MAX_COLUMNS : col_in_use;
    if (live > 0 && (live == SMV_MAX_COLUMNS || $urandom_range(0, 7) != 0))
      return $urandom_range(0, live - 1);
    return $urandom_range(live, SMV_MAX_COLUMNS - 1);
  endfunction

  task automatic send_word(input logic [1:0] op, input int unsigned col,
                           input int unsigned vv, input int unsigned mv);
    int                   gap;
    logic [SMV_COL_W-1:0] c;
    c = col[SMV_COL_W-1:0];
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_column_index <= c;
    in_vector_value <= vv;
    in_matrix_value <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED) words_sent++;
    if (op == OP_LOAD) loaded[c] = 1'b1;
  endtask

  // never read a store entry that was not loaded
  task automatic send_nonzero(input int unsigned col, input int unsigned mv);
    if (!loaded[col]) send_word(OP_LOAD, col, rand_value(), $urandom);
    send_word(OP_ACC, col, $urandom, mv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input int unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SMV_CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_COLUMN_COUNT) col_in_use = value;
  endtask

  task automatic random_step();
    int pick;
    int nz;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 4)) send_word(OP_LOAD, $urandom, rand_value(), $urandom);
    end else if (pick < 13) begin
      send_word(OP_UNUSED, $urandom, $urandom, $urandom);
    end else begin
      nz = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
      repeat (nz) begin
        if ($urandom_range(0, 19) == 0) send_word(OP_LOAD, $urandom, rand_value(), $urandom);
        send_nonzero(pick_column(), rand_value());
      end
      send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    end
  endtask

  // result side: random stall stretches, plus one long hold while words keep coming
  initial begin
    int seg;
    int pct;
    bit hold_used;
    forever begin
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 75;
          default: pct = 50;
        endcase
        seg = $urandom_range(10, 150);
        repeat (seg) begin
          if (hold_req && !hold_used) break;
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned col_plan [PHASES];
    int unsigned row_plan [PHASES];
    int          stop_at;
    bit          paused;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // vector edges: most negative, most positive, one, minus one, one half
    send_word(OP_LOAD, 0, 32'h8000_0000, $urandom);
    send_word(OP_LOAD, 1023, 32'h7fff_ffff, $urandom);
    send_word(OP_LOAD, 1, 32'h0001_0000, $urandom);
    send_word(OP_LOAD, 2, 32'hffff_0000, $urandom);
    send_word(OP_LOAD, 512, 32'h0000_8000, $urandom);
    // empty row
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // mixed signs
    send_word(OP_ACC, 1, $urandom, 32'h0002_0000);
    send_word(OP_ACC, 2, $urandom, 32'h0003_0000);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // truncation rounds toward minus infinity
    send_word(OP_ACC, 512, $urandom, 32'hffff_ffff);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // output clip
    send_word(OP_ACC, 1023, $urandom, 32'h7fff_ffff);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // accumulator clip
    repeat (3) send_word(OP_ACC, 0, $urandom, 32'h8000_0000);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    send_word(OP_UNUSED, 1023, $urandom, $urandom);
    // zero columns: everything skipped
    write_register(CFG_COLUMN_COUNT, 0);
    send_word(OP_ACC, 1, $urandom, 32'h0001_0000);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // one column: exact most negative sum plus a skipped column
    write_register(CFG_COLUMN_COUNT, 1);
    send_word(OP_ACC, 1, $urandom, 32'h0001_0000);
    send_word(OP_ACC, 0, $urandom, 32'h0001_0000);
    send_word(OP_CLOSE, $urandom, $urandom, $urandom);
    // row count lowered below the current row, then wrap
    write_register(CFG_ROW_COUNT, 2);
    repeat (3) send_word(OP_CLOSE, $urandom, $urandom, $urandom);

    col_plan = '{1024, 1, 2047, 0, $urandom_range(2, 1023), 1024, $urandom_range(1, 1024), 1023};
    row_plan = '{1024, 3, 1048576, 0, $urandom_range(1, 40), 2097151, 1, $urandom_range(2, 8)};
    paused = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_COLUMN_COUNT, col_plan[p]);
      write_register(CFG_ROW_COUNT, row_plan[p]);
      if (p == 2) hold_req <= 1'b1;
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
        if (p == 5 && !paused && words_sent >= stop_at - PHASE_WORDS / 2) begin
          paused = 1'b1;
          drain();
        end
        random_step();
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("sent %0d words over %0d register settings; %0d rows checked",
             words_sent, PHASES + 3, rows_checked);
    $display("rows with clipping: %0d, rows with skipped columns: %0d",
             clipped_rows, faulted_rows);
    if (error_count == 0 && rows_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
